>>> rtl/rsfr_pkg.sv
package rsfr_pkg;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_HEADER = 3'b010,
    PH_BODY   = 3'b100
  } phase_t;

  localparam logic [7:0] CH_START0 = 8'h25;  // '%'
  localparam logic [7:0] CH_START1 = 8'h24;  // '$'
  localparam logic [7:0] CH_ADDR   = 8'h40;  // '@'
  localparam logic [7:0] CH_HDR0   = 8'h44;  // 'D'
  localparam logic [7:0] CH_HDR1   = 8'h52;  // 'R'
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  localparam logic [3:0] FIRST_PAYLOAD_POS = 4'd3;
  localparam logic [7:0] OWN_ADDR_RESET    = 8'h01;
  localparam logic [1:0] REG_OWN_ADDR      = 2'd0;

  localparam int unsigned PAYLOAD_W = 64;
  localparam int unsigned OUT_TDATA_W = 72;

endpackage

>>> rtl/rs485_sensor_frame_receiver_unit.sv
// RS485 sensor frame receiver. One received byte is taken per in_ transaction
// and gives exactly one out_ transaction. Frames look like
// '%' '$' '@' <own_address> 'D' 'R' '=' <payload...>; payload bytes from frame
// position 3 are captured and presented with payload_valid when the byte at
// position FRAME_END_POS arrives. CR LF closes a line, clears line_busy and
// flags delivered when a completed frame is pending (reset also sets pending).
// A failed 'D'/'R' check sets board_lost until the next complete frame. Each
// byte is decoded combinationally straight into the output register, so a
// byte can be accepted every cycle; in_tready only drops while the output
// register holds a result that out_tready has not taken. own_address sits at
// APB address 0 and should only be written while no byte is in flight.
module rs485_sensor_frame_receiver_unit
  import rsfr_pkg::*;
#(
  parameter int unsigned PAYLOAD_BYTES = 8,
  parameter int unsigned FRAME_END_POS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
                      // [63:0] payload, [64] delivered, [65] line_busy,
                      // [66] board_lost, [71:67] zero
  output logic        out_tuser,    // [0] payload_valid
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int unsigned BUF_BYTES = (PAYLOAD_BYTES < 8) ? PAYLOAD_BYTES : 8;
  localparam int unsigned IDX_W = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1;

  logic [7:0] own_addr_r;
  phase_t     phase_r, phase_nxt;
  logic       addr_pend_r, addr_pend_nxt;
  logic [3:0] pos_r, pos_nxt;
  logic       start_arm_r, start_arm_nxt;
  logic       end_arm_r, end_arm_nxt;
  logic       busy_r, busy_nxt;
  logic       pending_r, pending_nxt;
  logic       lost_r, lost_nxt;
  logic [7:0] buf_r [BUF_BYTES];

  logic       out_valid_r;
  logic [PAYLOAD_W-1:0] payload_r, payload_nxt;
  logic       pv_r, pv_nxt;
  logic       dlv_r, dlv_nxt;

  logic       accept;
  logic       cfg_wr;
  logic [7:0] rx;
  logic [3:0] off;
  logic       cap;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr == REG_OWN_ADDR);
  assign cfg_prdata = (cfg_paddr == REG_OWN_ADDR) ? {24'd0, own_addr_r} : 32'd0;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign rx        = in_tdata;

  assign off = pos_r - FIRST_PAYLOAD_POS;
  assign cap = (phase_r == PH_BODY) && (pos_r >= FIRST_PAYLOAD_POS)
               && (off < 4'(BUF_BYTES));

  always_comb begin
    phase_nxt     = phase_r;
    addr_pend_nxt = addr_pend_r;
    pos_nxt       = pos_r;
    start_arm_nxt = start_arm_r;
    end_arm_nxt   = end_arm_r;
    busy_nxt      = busy_r;
    pending_nxt   = pending_r;
    lost_nxt      = lost_r;
    pv_nxt        = 1'b0;
    dlv_nxt       = 1'b0;
    payload_nxt   = '0;

    unique case (phase_r)
      PH_HEADER: begin
        if (addr_pend_r) begin
          if (rx == own_addr_r) begin
            phase_nxt = PH_BODY;
            pos_nxt   = 4'd0;
          end else begin
            phase_nxt = PH_IDLE;
          end
          addr_pend_nxt = 1'b0;
        end else if (rx == CH_ADDR) begin
          addr_pend_nxt = 1'b1;
        end
      end
      PH_BODY: begin
        if (pos_r < 4'd2) begin
          if (rx != ((pos_r == 4'd0) ? CH_HDR0 : CH_HDR1)) begin
            phase_nxt = PH_IDLE;
            lost_nxt  = 1'b1;
          end
        end else if (pos_r >= 4'(FRAME_END_POS)) begin
          phase_nxt   = PH_IDLE;
          pv_nxt      = 1'b1;
          pending_nxt = 1'b1;
          lost_nxt    = 1'b0;
          for (int k = 0; k < BUF_BYTES; k++) begin
            payload_nxt[8*k +: 8] = (cap && (off == 4'(k))) ? rx : buf_r[k];
          end
        end
        pos_nxt = pos_r + 4'd1;
      end
      default: begin
      end
    endcase

    if (start_arm_r) begin
      if (rx == CH_START1) begin
        start_arm_nxt = 1'b0;
        phase_nxt     = PH_HEADER;
        pos_nxt       = 4'd0;
        busy_nxt      = 1'b1;
      end
    end else if (rx == CH_START0) begin
      start_arm_nxt = 1'b1;
    end

    if (end_arm_r) begin
      if (rx == CH_LF) begin
        end_arm_nxt = 1'b0;
        busy_nxt    = 1'b0;
        if (pending_nxt) begin
          pending_nxt = 1'b0;
          dlv_nxt     = 1'b1;
        end
      end
    end else if (rx == CH_CR) begin
      end_arm_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_addr_r  <= OWN_ADDR_RESET;
      phase_r     <= PH_IDLE;
      addr_pend_r <= 1'b0;
      pos_r       <= 4'd0;
      start_arm_r <= 1'b0;
      end_arm_r   <= 1'b0;
      busy_r      <= 1'b0;
      pending_r   <= 1'b1;
      lost_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        own_addr_r <= cfg_pwdata[7:0];
      end
      if (accept) begin
        phase_r     <= phase_nxt;
        addr_pend_r <= addr_pend_nxt;
        pos_r       <= pos_nxt;
        start_arm_r <= start_arm_nxt;
        end_arm_r   <= end_arm_nxt;
        busy_r      <= busy_nxt;
        pending_r   <= pending_nxt;
        lost_r      <= lost_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (cap) begin
        buf_r[off[IDX_W-1:0]] <= rx;
      end
      payload_r <= payload_nxt;
      pv_r      <= pv_nxt;
      dlv_r     <= dlv_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, lost_r, busy_r, dlv_r, payload_r};
  assign out_tuser  = pv_r;

endmodule
